FILE: sv/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants for the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int PTR_W         = $clog2(STACK_DEPTH);
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    K_PUSH = 4'd0, K_IN = 4'd1, K_POP = 4'd2, K_DIV = 4'd3, K_SUB = 4'd4,
    K_ADD = 4'd5, K_MUL = 4'd6, K_OUT = 4'd7, K_HALT = 4'd8, K_SQRT = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIV0 = 3'd3, ST_NEGROOT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_MUL, S_DONE
  } state_t;

endpackage

FILE: sv/stack_machine_executor.sv
// Stack machine executor.
// Steps: push/in/halt go straight to done; pop/out/sqrt read one entry and the other
// ops two, then execute; mul adds a multiply state; div and sqrt iterate, one quotient
// or root bit a cycle; underflow, divide by zero and negative root skip the iterations.
// One instruction at a time: a new input transfer can come the cycle after the result
// transfer. Reset: count one (entry zero reads as zero), registers zero, not halted.
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one decoded stack-machine instruction per transfer.
// ----------------------------------------------------------------------------
module stack_machine_executor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         kind,
  input  logic               source_is_register,
  input  logic signed [31:0] immediate,
  input  logic [1:0]         register_number,
  input  logic signed [31:0] entered_value,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [2:0]         status,
  output logic               halted
);

  localparam int PW = sme_pkg::PTR_W;
  localparam int CW = sme_pkg::CNT_W;
  localparam int FB = sme_pkg::FRACTION_BITS;
  localparam logic [5:0] DIV_LAST = 6'(31 + FB);

  logic [31:0] mem [sme_pkg::STACK_DEPTH];
  logic [31:0] rd_data;
  logic        we;
  logic [PW-1:0] waddr, raddr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  sme_pkg::state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [31:0]   regs [4];
  logic          halt_flag;
  logic [3:0]    k;
  logic [1:0]    rn;
  logic [31:0]   opa, opb;
  logic          oka, okb;
  logic          zero_top;   // entry zero never written since reset
  logic [5:0]    iter;
  logic [63:0]   rem, quo, dvd;
  logic [31:0]   dvs;
  logic          neg;
  logic signed [63:0] prod;

  // read address for next pop, from current count
  logic [CW-1:0] cnt_m1, cnt_m2;
  assign cnt_m1 = cnt - CW'(1);
  assign cnt_m2 = cnt - CW'(2);

  always_comb begin
    state_next = state;
    unique case (state)
      sme_pkg::S_IDLE: if (in_valid && !in_stall) begin
        if (halt_flag) state_next = sme_pkg::S_DONE;
        else begin
          unique case (kind)
            sme_pkg::K_PUSH, sme_pkg::K_IN, sme_pkg::K_HALT: state_next = sme_pkg::S_DONE;
            sme_pkg::K_POP, sme_pkg::K_OUT, sme_pkg::K_SQRT, sme_pkg::K_DIV,
            sme_pkg::K_SUB, sme_pkg::K_ADD, sme_pkg::K_MUL: state_next = sme_pkg::S_RD1;
            default: state_next = sme_pkg::S_DONE;
          endcase
        end
      end
      sme_pkg::S_RD1: state_next = (k == sme_pkg::K_POP || k == sme_pkg::K_OUT ||
                                   k == sme_pkg::K_SQRT) ? sme_pkg::S_EXEC : sme_pkg::S_RD2;
      sme_pkg::S_RD2: state_next = sme_pkg::S_EXEC;
      sme_pkg::S_EXEC: begin
        unique case (k)
          sme_pkg::K_MUL:  state_next = sme_pkg::S_MUL;
          sme_pkg::K_SQRT: state_next = (!okb || opb[31]) ? sme_pkg::S_DONE : sme_pkg::S_ITER;
          sme_pkg::K_DIV:  state_next = (!oka || !okb || opb == '0) ? sme_pkg::S_DONE
                                                                     : sme_pkg::S_ITER;
          default:         state_next = sme_pkg::S_DONE;
        endcase
      end
      sme_pkg::S_ITER: if (iter == ((k == sme_pkg::K_SQRT) ? 6'd31 : DIV_LAST))
        state_next = sme_pkg::S_DONE;
      sme_pkg::S_MUL:  state_next = sme_pkg::S_DONE;
      sme_pkg::S_DONE: if (!res_stall) state_next = sme_pkg::S_IDLE;
      default: state_next = sme_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state != sme_pkg::S_IDLE);
  assign res_valid = (state == sme_pkg::S_DONE);
  assign halted    = halt_flag;
  // first operand of a binary op sits one below the top
  assign raddr     = (state == sme_pkg::S_RD1) ? cnt_m2[PW-1:0] : cnt_m1[PW-1:0];

  function automatic logic [31:0] clamp(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // memory write: at most one push per instruction, in the first done cycle
  logic        push_en;
  logic [31:0] push_v;
  always_comb begin
    we    = push_en && (cnt < CW'(sme_pkg::STACK_DEPTH));
    waddr = cnt[PW-1:0];
    wdata = push_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sme_pkg::S_IDLE;
      cnt <= CW'(1);
      halt_flag <= 1'b0;
      zero_top <= 1'b1;
      push_en <= 1'b0;
      for (int i = 0; i < 4; i++) regs[i] <= '0;
      out_valid <= 1'b0;
      out_value <= '0;
      status <= sme_pkg::ST_OK;
    end else begin
      state <= state_next;
      if (we && cnt == '0) zero_top <= 1'b0;
      unique case (state)
        sme_pkg::S_IDLE: if (in_valid && !in_stall) begin
          k <= kind; rn <= register_number;
          out_valid <= 1'b0; out_value <= '0;
          if (!halt_flag && (kind == sme_pkg::K_PUSH || kind == sme_pkg::K_IN) &&
              cnt >= CW'(sme_pkg::STACK_DEPTH))
            status <= sme_pkg::ST_OVER;
          else status <= sme_pkg::ST_OK;
          if (!halt_flag) begin
            if (kind == sme_pkg::K_HALT) halt_flag <= 1'b1;
            if ((kind == sme_pkg::K_PUSH || kind == sme_pkg::K_IN) &&
                cnt < CW'(sme_pkg::STACK_DEPTH)) begin
              push_en <= 1'b1;
              push_v <= (kind == sme_pkg::K_IN) ? entered_value :
                        (source_is_register ? regs[register_number] : immediate);
            end
          end
        end
        sme_pkg::S_RD1: begin
          // top was read with the count of the previous cycle
          okb <= (cnt != '0);
          opb <= (cnt == '0 || (cnt == CW'(1) && zero_top)) ? '0 : rd_data;
          if (cnt != '0) cnt <= cnt_m1;
        end
        sme_pkg::S_RD2: begin
          oka <= (cnt != '0);
          opa <= (cnt == '0 || (cnt == CW'(1) && zero_top)) ? '0 : rd_data;
          if (cnt != '0) cnt <= cnt_m1;
        end
        sme_pkg::S_EXEC: begin
          iter <= '0;
          unique case (k)
            sme_pkg::K_POP: begin
              regs[rn] <= opb;
              if (!okb) status <= sme_pkg::ST_UNDER;
            end
            sme_pkg::K_OUT: begin
              if (okb) begin out_valid <= 1'b1; out_value <= opb; end
              else status <= sme_pkg::ST_UNDER;
            end
            sme_pkg::K_SQRT: begin
              if (!okb || opb[31]) begin
                status <= okb ? sme_pkg::ST_NEGROOT : sme_pkg::ST_UNDER;
                push_en <= 1'b1; push_v <= '0;
              end else begin
                dvd <= 64'(opb) << FB; rem <= '0; quo <= '0;
              end
            end
            sme_pkg::K_ADD, sme_pkg::K_SUB: begin
              if (!oka || !okb) begin status <= sme_pkg::ST_UNDER; push_v <= '0; end
              else if (k == sme_pkg::K_ADD)
                push_v <= clamp(66'(signed'(opa)) + 66'(signed'(opb)));
              else push_v <= clamp(66'(signed'(opa)) - 66'(signed'(opb)));
              push_en <= 1'b1;
            end
            sme_pkg::K_MUL: begin
              prod <= signed'(opa) * signed'(opb);
            end
            default: begin // divide
              if (!oka || !okb || opb == '0) begin
                status <= (!oka || !okb) ? sme_pkg::ST_UNDER : sme_pkg::ST_DIV0;
                push_en <= 1'b1; push_v <= '0;
              end else begin
                neg <= opa[31] ^ opb[31];
                dvd <= (opa[31] ? 64'(-signed'(64'(signed'(opa)))) : 64'(opa)) << FB;
                dvs <= opb[31] ? 32'(-opb) : opb;
                rem <= '0; quo <= '0;
              end
            end
          endcase
        end
        sme_pkg::S_MUL: begin
          if (!oka || !okb) begin status <= sme_pkg::ST_UNDER; push_v <= '0; end
          else push_v <= clamp(66'(prod >>> FB));
          push_en <= 1'b1;
        end
        sme_pkg::S_ITER: begin
          if (k == sme_pkg::K_SQRT) begin
            // two radicand bits per step, 32 steps
            logic [65:0] trial;
            logic [65:0] r2;
            r2 = {rem[63:0], dvd[63:62]};
            trial = {quo[63:0], 2'b01};
            dvd <= dvd << 2;
            if (r2 >= trial) begin rem <= 64'(r2 - trial); quo <= {quo[62:0], 1'b1}; end
            else begin rem <= r2[63:0]; quo <= {quo[62:0], 1'b0}; end
            iter <= iter + 6'd1;
            if (iter == 6'd31) begin
              push_en <= 1'b1;
              push_v <= clamp(66'({quo[62:0], (r2 >= trial)}));
            end
          end else begin
            // restoring division over the shifted dividend bits
            logic [64:0] r1;
            r1 = {rem, dvd[31 + FB]};
            dvd <= dvd << 1;
            if (r1 >= 65'(dvs)) begin rem <= 64'(r1 - 65'(dvs)); quo <= {quo[62:0], 1'b1}; end
            else begin rem <= r1[63:0]; quo <= {quo[62:0], 1'b0}; end
            iter <= iter + 6'd1;
            if (iter == DIV_LAST) begin
              logic [63:0] q;
              q = {quo[62:0], (r1 >= 65'(dvs))};
              push_en <= 1'b1;
              push_v <= neg ? clamp(-66'(q)) : clamp(66'(q));
            end
          end
        end
        sme_pkg::S_DONE: push_en <= 1'b0;
        default: ;
      endcase
      if (we) cnt <= cnt + CW'(1);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(sme_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> status == sme_pkg::ST_OK)
    else $error("out with error status");
  assert property (@(posedge clk) disable iff (rst) $past(halt_flag) |-> halt_flag)
    else $error("halt cleared");
  assert property (@(posedge clk) disable iff (rst) we |-> state != sme_pkg::S_IDLE)
    else $error("write while idle");

endmodule

FILE: tb/stack_machine_executor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_tb
// Self-checking bench: drives decoded instructions with bursty timing, keeps a
// Q16.16 stack machine model of its own and compares every returned result.
// ----------------------------------------------------------------------------
module stack_machine_executor_tb;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic        ov;
    logic [31:0] value;
    logic [2:0]  st;
    logic        hlt;
  } result_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [3:0]         kind = '0;
  logic               source_is_register = 0;
  logic signed [31:0] immediate = '0;
  logic [1:0]         register_number = '0;
  logic signed [31:0] entered_value = '0;
  logic               res_valid;
  logic               res_stall = 0;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic [2:0]         status;
  logic               halted;

  stack_machine_executor u_dut (.*);

  // model state
  logic [31:0] stk [sme_pkg::STACK_DEPTH];
  int          depth_now;
  logic [31:0] regs [4];
  logic        halt_seen;

  result_t     pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  int          stall_mode = 0;

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit model_push(input logic [31:0] v);
    if (depth_now >= sme_pkg::STACK_DEPTH) return 0;
    stk[depth_now] = v;
    depth_now++;
    return 1;
  endfunction

  function automatic bit model_pop(output logic [31:0] v);
    v = '0;
    if (depth_now == 0) return 0;
    depth_now--;
    v = stk[depth_now];
    return 1;
  endfunction

  function automatic result_t execute_instr(input logic [3:0] k, input logic sr,
                                            input logic [31:0] imm, input logic [1:0] rn,
                                            input logic [31:0] ev);
    result_t     r = '0;
    logic [31:0] a, b;
    bit          oka, okb;
    longint      x, y, p;
    if (!halt_seen) begin
      case (k)
        sme_pkg::K_PUSH: if (!model_push(sr ? regs[rn] : imm)) r.st = sme_pkg::ST_OVER;
        sme_pkg::K_IN:   if (!model_push(ev)) r.st = sme_pkg::ST_OVER;
        sme_pkg::K_POP: begin
          if (!model_pop(a)) r.st = sme_pkg::ST_UNDER;
          regs[rn] = a;
        end
        sme_pkg::K_DIV, sme_pkg::K_SUB, sme_pkg::K_ADD, sme_pkg::K_MUL: begin
          okb = model_pop(b);
          oka = model_pop(a);
          x = longint'(signed'(a));
          y = longint'(signed'(b));
          a = '0;
          if (!okb || !oka) r.st = sme_pkg::ST_UNDER;
          else if (k == sme_pkg::K_DIV) begin
            if (y == 0) r.st = sme_pkg::ST_DIV0;
            else a = sat32((x <<< sme_pkg::FRACTION_BITS) / y);
          end else if (k == sme_pkg::K_SUB) a = sat32(x - y);
          else if (k == sme_pkg::K_ADD) a = sat32(x + y);
          else begin
            p = x * y;
            a = sat32(p >>> sme_pkg::FRACTION_BITS);  // arithmetic shift floors
          end
          void'(model_push(a));
        end
        sme_pkg::K_OUT: begin
          if (model_pop(a)) begin
            r.ov = 1;
            r.value = a;
          end else r.st = sme_pkg::ST_UNDER;
        end
        sme_pkg::K_HALT: halt_seen = 1;
        sme_pkg::K_SQRT: begin
          if (!model_pop(a)) r.st = sme_pkg::ST_UNDER;
          else if (a[31]) begin
            r.st = sme_pkg::ST_NEGROOT;
            a = '0;
          end else a = sat32(longint'(floor_root(longint'(a) << sme_pkg::FRACTION_BITS)));
          if (r.st != sme_pkg::ST_OK) a = '0;
          void'(model_push(a));
        end
        default: ;
      endcase
    end
    r.hlt = halt_seen;
    return r;
  endfunction

  // one instruction transfer, sender may idle between bursts
  task automatic send_instr(input logic [3:0] k, input logic sr, input logic [31:0] imm,
                            input logic [1:0] rn, input logic [31:0] ev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid <= 1;
    kind <= k;
    source_is_register <= sr;
    immediate <= imm;
    register_number <= rn;
    entered_value <= ev;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(execute_instr(k, sr, imm, rn, ev));
    burst_left--;
  endtask

  task automatic push_imm(input logic [31:0] v);
    send_instr(sme_pkg::K_PUSH, 1'b0, v, 2'($urandom), $urandom);
  endtask

  task automatic op(input logic [3:0] k);
    send_instr(k, 1'($urandom), $urandom, 2'($urandom), $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      res_stall <= 1;
      hold_left--;
    end else begin
      case (stall_mode)
        0: res_stall <= 0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= 1'($urandom_range(0, 1));
        default: res_stall <= ((cycles % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected transfer", 32'(status), 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_valid !== w.ov) report("out_valid", 32'(out_valid), 32'(w.ov));
        if (out_value !== w.value) report("out_value", out_value, w.value);
        if (status !== w.st) report("status", 32'(status), 32'(w.st));
        if (halted !== w.hlt) report("halted", 32'(halted), 32'(w.hlt));
      end
    end
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000);
      2: return -$urandom_range(0, 32'h0004_0000);
      3: return $urandom_range(0, 3) == 0 ? 32'h7fffffff :
                ($urandom_range(0, 1) ? 32'h80000000 : 32'h0);
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  task automatic test_directed();
    op(sme_pkg::K_OUT);             // the reset zero
    op(sme_pkg::K_OUT);             // empty: underflow
    op(sme_pkg::K_POP);             // empty pop
    op(sme_pkg::K_ADD);             // binary underflow, pushes zero
    op(sme_pkg::K_SQRT);
    op(sme_pkg::K_OUT);
    push_imm(32'h7fffffff);
    push_imm(32'h7fffffff);
    op(sme_pkg::K_ADD);             // saturates high
    push_imm(32'h80000000);
    op(sme_pkg::K_SUB);             // saturates high again
    send_instr(sme_pkg::K_IN, 1'b0, 32'd0, 2'd0, 32'h80000000);
    send_instr(sme_pkg::K_POP, 1'b0, 32'd0, 2'd3, 32'd0);
    send_instr(sme_pkg::K_PUSH, 1'b1, 32'd0, 2'd3, 32'd0);
    push_imm(32'hfffe8000);         // -1.5
    op(sme_pkg::K_MUL);
    push_imm(32'h0);
    op(sme_pkg::K_DIV);             // divide by zero
    push_imm(32'hffff0000);
    op(sme_pkg::K_SQRT);            // negative root
    push_imm(32'h00020000);
    op(sme_pkg::K_SQRT);
    send_instr(4'd15, 1'b1, 32'hffffffff, 2'd3, 32'hffffffff);
    op(sme_pkg::K_OUT);
    drain();
  endtask

  task automatic test_overflow();
    while (depth_now < sme_pkg::STACK_DEPTH)
      send_instr(sme_pkg::K_IN, 1'b0, 32'd0, 2'd0, rand_q());
    push_imm(32'h1234);
    send_instr(sme_pkg::K_IN, 1'b0, 32'd0, 2'd0, 32'h1);
    op(sme_pkg::K_MUL);
    while (depth_now > 0) op(sme_pkg::K_OUT);
    op(sme_pkg::K_SUB);
    drain();
  endtask

  task automatic test_pressure();
    @(posedge clk);
    hold_left = 400;
    repeat (20) send_instr(sme_pkg::K_IN, 1'b0, 32'd0, 2'd0, rand_q());
    repeat (20) op(sme_pkg::K_OUT);
    drain();
  endtask

  task automatic test_random(input int n);
    logic [3:0] k;
    int         r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (depth_now < 2 && r < 60) k = $urandom_range(0, 1) ? sme_pkg::K_PUSH : sme_pkg::K_IN;
      else if (depth_now > sme_pkg::STACK_DEPTH - 4 && r < 50) k = sme_pkg::K_OUT;
      else if (r < 25) k = sme_pkg::K_PUSH;
      else if (r < 35) k = sme_pkg::K_IN;
      else if (r < 42) k = sme_pkg::K_POP;
      else if (r < 50) k = sme_pkg::K_DIV;
      else if (r < 57) k = sme_pkg::K_SUB;
      else if (r < 64) k = sme_pkg::K_ADD;
      else if (r < 72) k = sme_pkg::K_MUL;
      else if (r < 86) k = sme_pkg::K_OUT;
      else if (r < 95) k = sme_pkg::K_SQRT;
      else k = 4'($urandom_range(10, 15));
      send_instr(k, 1'($urandom), rand_q(), 2'($urandom), rand_q());
    end
    drain();
  endtask

  task automatic test_halt();
    op(sme_pkg::K_HALT);
    repeat (12) send_instr(4'($urandom_range(0, 15)), 1'($urandom), $urandom,
                           2'($urandom), $urandom);
    drain();
  endtask

  initial begin
    depth_now = 1;
    foreach (stk[i]) stk[i] = '0;
    foreach (regs[i]) regs[i] = '0;
    halt_seen = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_overflow();
    test_pressure();
    test_random(1000);
    test_halt();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sme_pkg.sv
sv/stack_machine_executor.sv
tb/stack_machine_executor_tb.sv
